// ===== rtl/fser_pkg.sv =====
// Package for the entry record parser.
// Holds the parse phase type, the result struct and shared constants.
// No dependencies.
package fser_pkg;

  localparam int unsigned DLEN_BYTES        = 4;
  localparam int unsigned DCRC_BYTES        = 4;
  localparam int unsigned KID_COUNT_BYTES   = 4;
  localparam int unsigned KID_OFFSET_BYTES  = 4;
  localparam int unsigned META_LENGTH_BYTES = 2;

  localparam logic [7:0] TYPE_FILE = 8'd1;
  localparam logic [7:0] TYPE_DIR  = 8'd2;

  localparam logic REG_WANTED_META_TYPE = 1'b0;

  typedef enum logic [3:0] {
    PH_TYPE       = 4'd0,
    PH_NAMELEN    = 4'd1,
    PH_NAME       = 4'd2,
    PH_DATALEN    = 4'd3,
    PH_CRC        = 4'd4,
    PH_DATA       = 4'd5,
    PH_FLAGS      = 4'd6,
    PH_METACOUNT  = 4'd7,
    PH_METATYPE   = 4'd8,
    PH_METALEN    = 4'd9,
    PH_METADATA   = 4'd10,
    PH_CHILDCOUNT = 4'd11,
    PH_CHILDOFF   = 4'd12,
    PH_OUTSIDE    = 4'd13
  } phase_t;

  typedef struct packed {
    phase_t      kind;
    logic [7:0]  echo;
    logic [31:0] value;
    logic        complete;
    logic        match;
    logic        bad;
    logic        done;
  } result_t;

endpackage

// ===== rtl/fs_entry_record_parser.sv =====
// Top level of the entry record parser: input register, result register and
// configuration port. Depends on fser_pkg and fser_core.
//
// The parser takes one record byte per clock cycle and returns one tagged result
// per byte, in order. An accepted byte is held in the input register, is tagged
// and updates the parse state in combinational logic as it moves into the
// result register, which presents its result; bytes can follow back to back.
// The input stalls only while the input register holds a byte and the
// result register holds a stalled result.
// The matched metadata type is set through the register at address zero and
// must only be written while no transaction is in flight.
module fs_entry_record_parser (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_of_entry,
  input  logic [7:0]  in_data_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_field_kind,
  output logic [7:0]  out_byte_echo,
  output logic [31:0] out_field_value,
  output logic        out_field_complete,
  output logic        out_meta_match,
  output logic        out_type_bad,
  output logic        out_entry_done,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              in_valid_r, in_valid_nxt;
  logic              in_start_r;
  logic [7:0]        in_byte_r;
  logic              out_valid_r, out_valid_nxt;
  fser_pkg::result_t out_res_r;
  fser_pkg::result_t core_res;
  logic [7:0]        wanted_r;
  logic              take;
  logic              accept;
  logic              cfg_write;

  assign take     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !take;
  assign accept   = in_valid && !in_stall;

  fser_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (take),
    .start            (in_start_r),
    .data_byte        (in_byte_r),
    .wanted_meta_type (wanted_r),
    .res              (core_res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (take) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_start_r <= in_start_of_entry;
      in_byte_r  <= in_data_byte;
    end
    if (take) begin
      out_res_r <= core_res;
    end
  end

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == fser_pkg::REG_WANTED_META_TYPE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= 8'd0;
    end else if (cfg_write) begin
      wanted_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == fser_pkg::REG_WANTED_META_TYPE) ? {24'd0, wanted_r} : 32'd0;

  assign out_valid          = out_valid_r;
  assign out_field_kind     = out_res_r.kind;
  assign out_byte_echo      = out_res_r.echo;
  assign out_field_value    = out_res_r.value;
  assign out_field_complete = out_res_r.complete;
  assign out_meta_match     = out_res_r.match;
  assign out_type_bad       = out_res_r.bad;
  assign out_entry_done     = out_res_r.done;

endmodule

// ===== rtl/fser_core.sv =====
// Parse state of the entry record parser and the per-byte tagging logic.
// Uses fser_pkg for the phase type and the result struct.
module fser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 start,
  input  logic [7:0]           data_byte,
  input  logic [7:0]           wanted_meta_type,
  output fser_pkg::result_t    res
);

  fser_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  bif_r, bif_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] asm_r, asm_nxt;
  logic [7:0]  meta_left_r, meta_left_nxt;
  logic [31:0] children_left_r, children_left_nxt;
  logic        match_taken_r, match_taken_nxt;
  logic        item_matches_r, item_matches_nxt;

  fser_pkg::phase_t cur_phase;
  logic [1:0]  cur_bif;
  logic [31:0] cur_bytes_left;
  logic [31:0] cur_asm;
  logic [7:0]  cur_meta_left;
  logic [31:0] cur_children_left;
  logic        cur_match_taken;
  logic        cur_item_matches;

  logic [31:0] gathered;
  logic [31:0] bytes_dec;
  logic [31:0] children_dec;
  logic [7:0]  meta_dec;
  logic        last2;
  logic        last4;

  always_comb begin
    if (start) begin
      cur_phase         = fser_pkg::PH_TYPE;
      cur_bif           = 2'd0;
      cur_bytes_left    = 32'd0;
      cur_asm           = 32'd0;
      cur_meta_left     = 8'd0;
      cur_children_left = 32'd0;
      cur_match_taken   = 1'b0;
      cur_item_matches  = 1'b0;
    end else begin
      cur_phase         = phase_r;
      cur_bif           = bif_r;
      cur_bytes_left    = bytes_left_r;
      cur_asm           = asm_r;
      cur_meta_left     = meta_left_r;
      cur_children_left = children_left_r;
      cur_match_taken   = match_taken_r;
      cur_item_matches  = item_matches_r;
    end
  end

  always_comb begin
    unique case (cur_bif)
      2'd0: gathered = {24'd0, data_byte};
      2'd1: gathered = cur_asm | {16'd0, data_byte, 8'd0};
      2'd2: gathered = cur_asm | {8'd0, data_byte, 16'd0};
      2'd3: gathered = cur_asm | {data_byte, 24'd0};
      default: gathered = {24'd0, data_byte};
    endcase
    last2        = ({1'b0, cur_bif} + 3'd1) >= 3'(fser_pkg::META_LENGTH_BYTES);
    last4        = ({1'b0, cur_bif} + 3'd1) >= 3'(fser_pkg::DLEN_BYTES);
    bytes_dec    = cur_bytes_left - 32'd1;
    children_dec = cur_children_left - 32'd1;
    meta_dec     = cur_meta_left - 8'd1;
  end

  always_comb begin
    phase_nxt         = cur_phase;
    bif_nxt           = cur_bif;
    bytes_left_nxt    = cur_bytes_left;
    asm_nxt           = cur_asm;
    meta_left_nxt     = cur_meta_left;
    children_left_nxt = cur_children_left;
    match_taken_nxt   = cur_match_taken;
    item_matches_nxt  = cur_item_matches;

    res.kind     = cur_phase;
    res.echo     = data_byte;
    res.value    = 32'd0;
    res.complete = 1'b0;
    res.match    = 1'b0;
    res.bad      = 1'b0;
    res.done     = 1'b0;

    unique case (cur_phase)
      fser_pkg::PH_TYPE: begin
        res.value    = {24'd0, data_byte};
        res.complete = 1'b1;
        res.bad      = (data_byte != fser_pkg::TYPE_FILE) && (data_byte != fser_pkg::TYPE_DIR);
        phase_nxt    = fser_pkg::PH_NAMELEN;
      end
      fser_pkg::PH_NAMELEN: begin
        res.value      = {24'd0, data_byte};
        res.complete   = 1'b1;
        bytes_left_nxt = {24'd0, data_byte};
        bif_nxt        = 2'd0;
        phase_nxt      = (data_byte != 8'd0) ? fser_pkg::PH_NAME : fser_pkg::PH_DATALEN;
      end
      fser_pkg::PH_NAME: begin
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == 32'd0) begin
          res.complete = 1'b1;
          phase_nxt    = fser_pkg::PH_DATALEN;
        end
      end
      fser_pkg::PH_DATALEN: begin
        asm_nxt      = gathered;
        res.value    = gathered;
        res.complete = last4;
        bif_nxt      = last4 ? 2'd0 : cur_bif + 2'd1;
        if (last4) begin
          bytes_left_nxt = gathered;
          phase_nxt      = fser_pkg::PH_CRC;
        end
      end
      fser_pkg::PH_CRC: begin
        asm_nxt      = gathered;
        res.value    = gathered;
        res.complete = last4;
        bif_nxt      = last4 ? 2'd0 : cur_bif + 2'd1;
        if (last4) begin
          phase_nxt = (cur_bytes_left != 32'd0) ? fser_pkg::PH_DATA : fser_pkg::PH_FLAGS;
        end
      end
      fser_pkg::PH_DATA: begin
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == 32'd0) begin
          res.complete = 1'b1;
          phase_nxt    = fser_pkg::PH_FLAGS;
        end
      end
      fser_pkg::PH_FLAGS: begin
        res.value    = {24'd0, data_byte};
        res.complete = 1'b1;
        phase_nxt    = fser_pkg::PH_METACOUNT;
      end
      fser_pkg::PH_METACOUNT: begin
        res.value     = {24'd0, data_byte};
        res.complete  = 1'b1;
        meta_left_nxt = data_byte;
        bif_nxt       = 2'd0;
        phase_nxt     = (data_byte != 8'd0) ? fser_pkg::PH_METATYPE : fser_pkg::PH_CHILDCOUNT;
      end
      fser_pkg::PH_METATYPE: begin
        res.value        = {24'd0, data_byte};
        res.complete     = 1'b1;
        item_matches_nxt = !cur_match_taken && (data_byte == wanted_meta_type);
        match_taken_nxt  = cur_match_taken || item_matches_nxt;
        res.match        = item_matches_nxt;
        bif_nxt          = 2'd0;
        phase_nxt        = fser_pkg::PH_METALEN;
      end
      fser_pkg::PH_METALEN: begin
        res.match    = cur_item_matches;
        asm_nxt      = gathered;
        res.value    = gathered;
        res.complete = last2;
        bif_nxt      = last2 ? 2'd0 : cur_bif + 2'd1;
        if (last2) begin
          bytes_left_nxt = gathered;
          if (gathered != 32'd0) begin
            phase_nxt = fser_pkg::PH_METADATA;
          end else begin
            item_matches_nxt = 1'b0;
            meta_left_nxt    = meta_dec;
            phase_nxt        = (meta_dec != 8'd0) ? fser_pkg::PH_METATYPE
                                                  : fser_pkg::PH_CHILDCOUNT;
          end
        end
      end
      fser_pkg::PH_METADATA: begin
        res.match      = cur_item_matches;
        bytes_left_nxt = bytes_dec;
        if (bytes_dec == 32'd0) begin
          res.complete     = 1'b1;
          item_matches_nxt = 1'b0;
          meta_left_nxt    = meta_dec;
          phase_nxt        = (meta_dec != 8'd0) ? fser_pkg::PH_METATYPE
                                                : fser_pkg::PH_CHILDCOUNT;
        end
      end
      fser_pkg::PH_CHILDCOUNT: begin
        asm_nxt      = gathered;
        res.value    = gathered;
        res.complete = last4;
        bif_nxt      = last4 ? 2'd0 : cur_bif + 2'd1;
        if (last4) begin
          children_left_nxt = gathered;
          if (gathered != 32'd0) begin
            phase_nxt = fser_pkg::PH_CHILDOFF;
          end else begin
            res.done  = 1'b1;
            phase_nxt = fser_pkg::PH_OUTSIDE;
          end
        end
      end
      fser_pkg::PH_CHILDOFF: begin
        asm_nxt      = gathered;
        res.value    = gathered;
        res.complete = last4;
        bif_nxt      = last4 ? 2'd0 : cur_bif + 2'd1;
        if (last4) begin
          children_left_nxt = children_dec;
          if (children_dec == 32'd0) begin
            res.done  = 1'b1;
            phase_nxt = fser_pkg::PH_OUTSIDE;
          end
        end
      end
      default: begin
        res.kind = fser_pkg::PH_OUTSIDE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= fser_pkg::PH_OUTSIDE;
      bif_r           <= 2'd0;
      bytes_left_r    <= 32'd0;
      asm_r           <= 32'd0;
      meta_left_r     <= 8'd0;
      children_left_r <= 32'd0;
      match_taken_r   <= 1'b0;
      item_matches_r  <= 1'b0;
    end else if (step_en) begin
      phase_r         <= phase_nxt;
      bif_r           <= bif_nxt;
      bytes_left_r    <= bytes_left_nxt;
      asm_r           <= asm_nxt;
      meta_left_r     <= meta_left_nxt;
      children_left_r <= children_left_nxt;
      match_taken_r   <= match_taken_nxt;
      item_matches_r  <= item_matches_nxt;
    end
  end

endmodule
